FILE: hdl/civrs_pkg.sv
// Shared types, constants and field layout for the index/value receive mailbox.
`default_nettype none

package civrs_pkg;

  localparam int STORE_DEPTH_DEFAULT = 16;

  localparam int OP_W        = 2;
  localparam int CAN_ID_W    = 11;
  localparam int LEN_W       = 4;
  localparam int WORD16_W    = 16;
  localparam int READ_IDX_W  = 8;
  localparam int RANGE_W     = 4;
  localparam int ADDR_FIELD_W = 5;
  localparam int SENDER_W    = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;

  localparam int CAN_ID_LSB  = 0;
  localparam int LEN_LSB     = CAN_ID_LSB + CAN_ID_W;
  localparam int FI_LSB      = LEN_LSB + LEN_W;
  localparam int FV_LSB      = FI_LSB + WORD16_W;
  localparam int SI_LSB      = FV_LSB + WORD16_W;
  localparam int SV_LSB      = SI_LSB + WORD16_W;
  localparam int RI_LSB      = SV_LSB + WORD16_W;
  localparam int RS_LSB      = RI_LSB + READ_IDX_W;
  localparam int RE_LSB      = RS_LSB + RANGE_W;
  localparam int IN_BITS     = RE_LSB + RANGE_W;
  localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_BITS    = WORD16_W + 1;
  localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  localparam int WORD_W      = WORD16_W + 1;
  localparam int FLAG_BIT    = WORD16_W;

  localparam logic [CFG_DATA_W-1:0] MAX_INDEX_RESET      = 5'd16;
  localparam logic [CFG_DATA_W-1:0] MODULE_ADDRESS_RESET = 5'd0;
  localparam logic [WORD16_W-1:0]   OUT_OF_RANGE         = 16'hFFFF;
  localparam logic [LEN_W-1:0]      LEN_TWO_PAIRS_A      = 4'd8;
  localparam logic [LEN_W-1:0]      LEN_TWO_PAIRS_B      = 4'd9;

  localparam logic [CFG_INDEX_W-1:0] REG_MODULE_ADDRESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_INDEX      = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_RECEIVE = 2'd0,
    OP_READ    = 2'd1,
    OP_FLAG    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR1,
    ST_PAIR2,
    ST_READ,
    ST_FLAG,
    ST_CLEAR
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/can_index_value_receive_store.sv
// Receive mailbox for index/value frames: store memory, sequencer and output register.
// Receive: if addressed, writes sender entry, then first pair, then any second pair.
// Value read and flag read: the stored word is registered, then the result is loaded
// into the output register; a new read waits until that register is free or drained.
// Range clear: clears entries from the lower bound to the upper, one entry per cycle.
// Synchronous reset clears all per-entry valid bits at once, so every entry reads as
// zero with its flag clear; there is no clearing pass.
`default_nettype none

module can_index_value_receive_store #(
  parameter int STORE_DEPTH = civrs_pkg::STORE_DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // can_id, length_code, first_index, first_value, second_index, second_value,
  // read_index, range_start, range_end, zero pad
  input  wire logic [civrs_pkg::S_TDATA_W-1:0]   s_tdata,
  // operation
  input  wire logic [civrs_pkg::OP_W-1:0]        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // read_value, flag_was_set, zero pad
  output logic [civrs_pkg::M_TDATA_W-1:0]        m_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [civrs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [civrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [civrs_pkg::WORD16_W:0]   DEPTH_W17 = 17'(STORE_DEPTH);
  localparam logic [civrs_pkg::READ_IDX_W:0] DEPTH_W9  = 9'(STORE_DEPTH);
  localparam logic [civrs_pkg::RANGE_W+4:0]  DEPTH_W9R = 9'(STORE_DEPTH);

  civrs_pkg::state_t state, state_next;

  logic [civrs_pkg::CFG_DATA_W-1:0] module_address;
  logic [civrs_pkg::CFG_DATA_W-1:0] max_index;

  logic [civrs_pkg::WORD_W-1:0] mem [STORE_DEPTH];
  logic [civrs_pkg::WORD_W-1:0] mem_q;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [civrs_pkg::WORD_W-1:0] mem_wdata;
  logic [AW-1:0]                mem_raddr;

  logic [STORE_DEPTH-1:0] valid;
  logic                   valid_set;
  logic [AW-1:0]          valid_set_addr;
  logic                   valid_clr;

  civrs_pkg::op_t in_op;
  logic [civrs_pkg::CAN_ID_W-1:0]   in_can_id;
  logic [civrs_pkg::LEN_W-1:0]      in_len;
  logic [civrs_pkg::WORD16_W-1:0]   in_fi, in_fv, in_si, in_sv;
  logic [civrs_pkg::READ_IDX_W-1:0] in_ri;
  logic [civrs_pkg::RANGE_W-1:0]    in_rs, in_re;

  logic accept, addressed, two_pairs_in;
  logic fi_ok, si_ok, p1_ok_in, p2_ok_in;
  logic ri_in_store, ri_below_max;

  logic                           p1_ok, p2_ok, two_pairs;
  logic [AW-1:0]                  p1_addr, p2_addr;
  logic [civrs_pkg::WORD16_W-1:0] p1_val, p2_val;
  logic [AW-1:0]                  rd_addr;
  logic                           rd_inrange;
  logic [civrs_pkg::RANGE_W-1:0]  cur, clr_hi;
  logic                           cur_in_store;
  logic                           flag_hit;

  logic                           out_load;
  logic [civrs_pkg::WORD16_W-1:0] out_value;
  logic                           out_flag;

  assign in_op     = civrs_pkg::op_t'(s_tuser);
  assign in_can_id = s_tdata[civrs_pkg::CAN_ID_LSB +: civrs_pkg::CAN_ID_W];
  assign in_len    = s_tdata[civrs_pkg::LEN_LSB +: civrs_pkg::LEN_W];
  assign in_fi     = s_tdata[civrs_pkg::FI_LSB +: civrs_pkg::WORD16_W];
  assign in_fv     = s_tdata[civrs_pkg::FV_LSB +: civrs_pkg::WORD16_W];
  assign in_si     = s_tdata[civrs_pkg::SI_LSB +: civrs_pkg::WORD16_W];
  assign in_sv     = s_tdata[civrs_pkg::SV_LSB +: civrs_pkg::WORD16_W];
  assign in_ri     = s_tdata[civrs_pkg::RI_LSB +: civrs_pkg::READ_IDX_W];
  assign in_rs     = s_tdata[civrs_pkg::RS_LSB +: civrs_pkg::RANGE_W];
  assign in_re     = s_tdata[civrs_pkg::RE_LSB +: civrs_pkg::RANGE_W];

  assign accept    = s_tvalid && s_tready;
  assign addressed = (in_can_id[civrs_pkg::CAN_ID_W-1 -: civrs_pkg::ADDR_FIELD_W]
                      == module_address);
  assign two_pairs_in = (in_len == civrs_pkg::LEN_TWO_PAIRS_A) ||
                        (in_len == civrs_pkg::LEN_TWO_PAIRS_B);

  assign fi_ok = ({1'b0, in_fi} < DEPTH_W17) && (in_fi < 16'(max_index));
  assign si_ok = ({1'b0, in_si} < DEPTH_W17) && (in_si < 16'(max_index));

  // Pairs aimed at the sender entry are dropped because the sender write wins,
  // and a first pair hit again by the second pair is dropped as well.
  assign p2_ok_in = two_pairs_in && si_ok && (in_si != '0);
  assign p1_ok_in = fi_ok && (in_fi != '0) && !(two_pairs_in && si_ok && (in_si == in_fi));

  assign ri_in_store  = ({1'b0, in_ri} < DEPTH_W9);
  assign ri_below_max = (in_ri < 8'(max_index));

  assign cur_in_store = (9'(cur) < DEPTH_W9R);
  assign flag_hit     = rd_inrange && valid[rd_addr] && mem_q[civrs_pkg::FLAG_BIT];
  assign mem_raddr    = AW'(in_ri);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= civrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    valid_set      = 1'b0;
    valid_set_addr = '0;
    valid_clr      = 1'b0;
    out_load       = 1'b0;
    out_value      = '0;
    out_flag       = 1'b0;
    case (state)
      civrs_pkg::ST_IDLE: begin
        s_tready = !m_tvalid || m_tready ||
                   (in_op == civrs_pkg::OP_RECEIVE) || (in_op == civrs_pkg::OP_CLEAR);
        if (s_tvalid && s_tready) begin
          case (in_op)
            civrs_pkg::OP_RECEIVE: begin
              if (addressed) begin
                mem_we         = 1'b1;
                mem_waddr      = '0;
                mem_wdata      = {1'b1, 11'd0, in_can_id[civrs_pkg::SENDER_W-1:0]};
                valid_set      = 1'b1;
                valid_set_addr = '0;
                state_next     = civrs_pkg::ST_PAIR1;
              end
            end
            civrs_pkg::OP_READ:  state_next = civrs_pkg::ST_READ;
            civrs_pkg::OP_FLAG:  state_next = civrs_pkg::ST_FLAG;
            civrs_pkg::OP_CLEAR: state_next = civrs_pkg::ST_CLEAR;
            default:             state_next = civrs_pkg::ST_IDLE;
          endcase
        end
      end
      civrs_pkg::ST_PAIR1: begin
        if (p1_ok) begin
          mem_we         = 1'b1;
          mem_waddr      = p1_addr;
          mem_wdata      = {1'b1, p1_val};
          valid_set      = 1'b1;
          valid_set_addr = p1_addr;
        end
        state_next = two_pairs ? civrs_pkg::ST_PAIR2 : civrs_pkg::ST_IDLE;
      end
      civrs_pkg::ST_PAIR2: begin
        if (p2_ok) begin
          mem_we         = 1'b1;
          mem_waddr      = p2_addr;
          mem_wdata      = {1'b1, p2_val};
          valid_set      = 1'b1;
          valid_set_addr = p2_addr;
        end
        state_next = civrs_pkg::ST_IDLE;
      end
      civrs_pkg::ST_READ: begin
        out_load = 1'b1;
        if (!rd_inrange) begin
          out_value = civrs_pkg::OUT_OF_RANGE;
        end else if (valid[rd_addr]) begin
          out_value = mem_q[civrs_pkg::WORD16_W-1:0];
        end
        state_next = civrs_pkg::ST_IDLE;
      end
      civrs_pkg::ST_FLAG: begin
        out_load = 1'b1;
        out_flag = flag_hit;
        if (flag_hit) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr;
          mem_wdata = {1'b0, mem_q[civrs_pkg::WORD16_W-1:0]};
        end
        state_next = civrs_pkg::ST_IDLE;
      end
      civrs_pkg::ST_CLEAR: begin
        valid_clr = cur_in_store;
        if (cur == clr_hi) begin
          state_next = civrs_pkg::ST_IDLE;
        end
      end
      default: state_next = civrs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_ok     <= p1_ok_in;
      p2_ok     <= p2_ok_in;
      two_pairs <= two_pairs_in;
      p1_addr   <= AW'(in_fi);
      p2_addr   <= AW'(in_si);
      p1_val    <= in_fv;
      p2_val    <= in_sv;
      rd_addr   <= AW'(in_ri);
      rd_inrange <= (in_op == civrs_pkg::OP_READ) ? (ri_in_store && ri_below_max)
                                                  : ri_in_store;
      cur       <= (in_rs > in_re) ? in_re : in_rs;
      clr_hi    <= (in_rs > in_re) ? in_rs : in_re;
    end else if (state == civrs_pkg::ST_CLEAR) begin
      cur <= cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (valid_set) begin
      valid[valid_set_addr] <= 1'b1;
    end else if (valid_clr) begin
      valid[AW'(cur)] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      module_address <= civrs_pkg::MODULE_ADDRESS_RESET;
      max_index      <= civrs_pkg::MAX_INDEX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        civrs_pkg::REG_MODULE_ADDRESS: module_address <= cfg_data;
        civrs_pkg::REG_MAX_INDEX:      max_index      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= civrs_pkg::M_TDATA_W'({out_flag, out_value});
    end
  end

`ifndef SYNTH
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == civrs_pkg::ST_IDLE))
    else $error("input taken outside idle");

  a_out_free_on_load: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !m_tvalid)
    else $error("result loaded over a waiting result");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (state == civrs_pkg::ST_CLEAR) && (cur == clr_hi) |=> (state == civrs_pkg::ST_IDLE))
    else $error("range clear ran past its upper bound");

  a_pair_not_sender: assert property (@(posedge clk) disable iff (rst)
    mem_we && ((state == civrs_pkg::ST_PAIR1) || (state == civrs_pkg::ST_PAIR2))
    |-> (mem_waddr != '0))
    else $error("pair write overrode the sender entry");

  a_reset_clears_valid: assert property (@(posedge clk)
    $past(rst) |-> (valid == '0))
    else $error("valid bits not cleared by reset");
`endif

endmodule

`default_nettype wire

FILE: verif/can_index_value_receive_store_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the index/value receive mailbox.
module can_index_value_receive_store_tb;

  localparam int DEPTH         = civrs_pkg::STORE_DEPTH_DEFAULT;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;

  typedef struct {
    civrs_pkg::op_t                   op;
    logic [civrs_pkg::CAN_ID_W-1:0]   can_id;
    logic [civrs_pkg::LEN_W-1:0]      len;
    logic [civrs_pkg::WORD16_W-1:0]   idx1;
    logic [civrs_pkg::WORD16_W-1:0]   val1;
    logic [civrs_pkg::WORD16_W-1:0]   idx2;
    logic [civrs_pkg::WORD16_W-1:0]   val2;
    logic [civrs_pkg::READ_IDX_W-1:0] read_idx;
    logic [civrs_pkg::RANGE_W-1:0]    bound_a;
    logic [civrs_pkg::RANGE_W-1:0]    bound_b;
  } frame_t;

  typedef struct {
    logic [civrs_pkg::WORD16_W-1:0] value;
    logic                           flag;
  } reply_t;

  logic                              clk;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  // can_id, length_code, first_index, first_value, second_index, second_value,
  // read_index, range_start, range_end, zero pad
  logic [civrs_pkg::S_TDATA_W-1:0]   s_tdata;
  // operation
  logic [civrs_pkg::OP_W-1:0]        s_tuser;
  logic                              m_tvalid;
  logic                              m_tready;
  // read_value, flag_was_set, zero pad
  logic [civrs_pkg::M_TDATA_W-1:0]   m_tdata;
  logic                              cfg_we;
  logic [civrs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [civrs_pkg::CFG_DATA_W-1:0]  cfg_data;

  logic [civrs_pkg::WORD16_W-1:0]    mbx_value [DEPTH];
  logic                              mbx_flag [DEPTH];
  logic [civrs_pkg::CFG_DATA_W-1:0]  addr_now;
  logic [civrs_pkg::CFG_DATA_W-1:0]  max_now;
  reply_t                            reply_q [$];

  int fail_count = 0;
  int idle_cycles = 0;
  int sender_gap_max = 19;
  int reader_stall_max = 19;
  int hold_request = 0;

  can_index_value_receive_store uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void mailbox_predict(frame_t f);
    int     lim;
    int     lo;
    int     hi;
    int     t;
    reply_t r;
    lim = (max_now < DEPTH) ? int'(max_now) : DEPTH;
    r.value = '0;
    r.flag = 1'b0;
    case (f.op)
      civrs_pkg::OP_RECEIVE: begin
        if (f.can_id[civrs_pkg::CAN_ID_W-1 -: civrs_pkg::ADDR_FIELD_W] == addr_now) begin
          if (f.idx1 < lim) begin
            mbx_value[f.idx1] = f.val1;
            mbx_flag[f.idx1] = 1'b1;
          end
          if ((f.len == civrs_pkg::LEN_TWO_PAIRS_A || f.len == civrs_pkg::LEN_TWO_PAIRS_B) &&
              f.idx2 < lim) begin
            mbx_value[f.idx2] = f.val2;
            mbx_flag[f.idx2] = 1'b1;
          end
          mbx_value[0] = {{(civrs_pkg::WORD16_W-civrs_pkg::SENDER_W){1'b0}},
                          f.can_id[civrs_pkg::SENDER_W-1:0]};
          mbx_flag[0] = 1'b1;
        end
      end
      civrs_pkg::OP_READ: begin
        r.value = (f.read_idx < lim) ? mbx_value[f.read_idx] : civrs_pkg::OUT_OF_RANGE;
        reply_q.push_back(r);
      end
      civrs_pkg::OP_FLAG: begin
        if (f.read_idx < DEPTH) begin
          r.flag = mbx_flag[f.read_idx];
          mbx_flag[f.read_idx] = 1'b0;
        end
        reply_q.push_back(r);
      end
      civrs_pkg::OP_CLEAR: begin
        lo = int'(f.bound_a);
        hi = int'(f.bound_b);
        if (lo > hi) begin
          t = lo;
          lo = hi;
          hi = t;
        end
        for (int i = lo; i <= hi; i++) begin
          if (i < DEPTH) begin
            mbx_value[i] = '0;
            mbx_flag[i] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic frame_t frame_item(logic [civrs_pkg::CAN_ID_W-1:0] id,
                                        logic [civrs_pkg::LEN_W-1:0] len,
                                        logic [civrs_pkg::WORD16_W-1:0] i1,
                                        logic [civrs_pkg::WORD16_W-1:0] v1,
                                        logic [civrs_pkg::WORD16_W-1:0] i2,
                                        logic [civrs_pkg::WORD16_W-1:0] v2);
    frame_t f;
    f = '{civrs_pkg::OP_RECEIVE, id, len, i1, v1, i2, v2, '0, '0, '0};
    return f;
  endfunction

  function automatic frame_t query_item(civrs_pkg::op_t op,
                                        logic [civrs_pkg::READ_IDX_W-1:0] idx);
    frame_t f;
    f = '{op, '0, '0, '0, '0, '0, '0, idx, '0, '0};
    return f;
  endfunction

  function automatic frame_t clear_item(logic [civrs_pkg::RANGE_W-1:0] a,
                                        logic [civrs_pkg::RANGE_W-1:0] b);
    frame_t f;
    f = '{civrs_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, a, b};
    return f;
  endfunction

  task automatic send_frame(frame_t f);
    logic [civrs_pkg::S_TDATA_W-1:0] payload;
    int                              gap;
    payload = '0;
    payload[civrs_pkg::CAN_ID_LSB +: civrs_pkg::CAN_ID_W] = f.can_id;
    payload[civrs_pkg::LEN_LSB +: civrs_pkg::LEN_W] = f.len;
    payload[civrs_pkg::FI_LSB +: civrs_pkg::WORD16_W] = f.idx1;
    payload[civrs_pkg::FV_LSB +: civrs_pkg::WORD16_W] = f.val1;
    payload[civrs_pkg::SI_LSB +: civrs_pkg::WORD16_W] = f.idx2;
    payload[civrs_pkg::SV_LSB +: civrs_pkg::WORD16_W] = f.val2;
    payload[civrs_pkg::RI_LSB +: civrs_pkg::READ_IDX_W] = f.read_idx;
    payload[civrs_pkg::RS_LSB +: civrs_pkg::RANGE_W] = f.bound_a;
    payload[civrs_pkg::RE_LSB +: civrs_pkg::RANGE_W] = f.bound_b;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= f.op;
    s_tdata <= payload;
    do @(posedge clk); while (!s_tready);
    mailbox_predict(f);
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle_block();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [civrs_pkg::CFG_INDEX_W-1:0] idx,
                           logic [civrs_pkg::CFG_DATA_W-1:0] val);
    settle_block();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      civrs_pkg::REG_MODULE_ADDRESS: addr_now = val;
      civrs_pkg::REG_MAX_INDEX:      max_now = val;
      default: begin
      end
    endcase
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    int     roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) f.op = civrs_pkg::OP_RECEIVE;
    else if (roll < 65) f.op = civrs_pkg::OP_READ;
    else if (roll < 85) f.op = civrs_pkg::OP_FLAG;
    else f.op = civrs_pkg::OP_CLEAR;
    f.can_id = civrs_pkg::CAN_ID_W'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      f.can_id[civrs_pkg::CAN_ID_W-1 -: civrs_pkg::ADDR_FIELD_W] = addr_now;
    end
    if ($urandom_range(0, 3) == 0) f.len = civrs_pkg::LEN_W'($urandom);
    else f.len = $urandom_range(0, 1) ? civrs_pkg::LEN_TWO_PAIRS_A : civrs_pkg::LEN_TWO_PAIRS_B;
    f.idx1 = civrs_pkg::WORD16_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                              : $urandom_range(0, DEPTH + 1));
    f.idx2 = civrs_pkg::WORD16_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                              : $urandom_range(0, DEPTH + 1));
    f.val1 = civrs_pkg::WORD16_W'($urandom);
    f.val2 = civrs_pkg::WORD16_W'($urandom);
    f.read_idx = civrs_pkg::READ_IDX_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                                    : $urandom_range(0, DEPTH + 1));
    f.bound_a = civrs_pkg::RANGE_W'($urandom);
    f.bound_b = civrs_pkg::RANGE_W'($urandom);
    return f;
  endfunction

  task automatic test_reset_contents();
    send_frame(query_item(civrs_pkg::OP_READ, 8'd0));
    send_frame(query_item(civrs_pkg::OP_FLAG, 8'(DEPTH - 1)));
  endtask

  task automatic test_frame_storage();
    // The pair aimed at entry 0 is overwritten by the sender number.
    send_frame(frame_item(11'b00000_1_11111, civrs_pkg::LEN_TWO_PAIRS_A,
                          16'd15, 16'hFFFF, 16'd0, 16'h1234));
    send_frame(frame_item(11'b00000_0_01010, civrs_pkg::LEN_TWO_PAIRS_B,
                          16'd16, 16'hAAAA, 16'd3, 16'h0000));
    send_frame(frame_item(11'b00000_1_00000, 4'd15, 16'd2, 16'h5555, 16'd4, 16'h7777));
    send_frame(frame_item(11'h7FF, civrs_pkg::LEN_TWO_PAIRS_A,
                          16'd5, 16'h0001, 16'd6, 16'h0002));
    send_frame(frame_item(11'b00000_0_11111, civrs_pkg::LEN_TWO_PAIRS_A,
                          16'hFFFF, 16'h0001, 16'd16, 16'h2));
  endtask

  task automatic test_value_and_flag_reads();
    send_frame(query_item(civrs_pkg::OP_READ, 8'(DEPTH - 1)));
    send_frame(query_item(civrs_pkg::OP_READ, 8'd0));
    send_frame(query_item(civrs_pkg::OP_READ, 8'd2));
    send_frame(query_item(civrs_pkg::OP_READ, 8'd4));
    send_frame(query_item(civrs_pkg::OP_READ, 8'(DEPTH)));
    send_frame(query_item(civrs_pkg::OP_READ, 8'hFF));
    send_frame(query_item(civrs_pkg::OP_FLAG, 8'd0));
    send_frame(query_item(civrs_pkg::OP_FLAG, 8'd0));
    send_frame(query_item(civrs_pkg::OP_FLAG, 8'hFF));
    send_frame(query_item(civrs_pkg::OP_FLAG, 8'(DEPTH)));
  endtask

  task automatic test_range_clear();
    send_frame(clear_item(4'd15, 4'd0));
    send_frame(query_item(civrs_pkg::OP_READ, 8'(DEPTH - 1)));
    send_frame(query_item(civrs_pkg::OP_FLAG, 8'd3));
    send_frame(clear_item(4'd3, 4'd3));
  endtask

  task automatic test_register_extremes();
    write_reg(civrs_pkg::REG_MODULE_ADDRESS, 5'd31);
    write_reg(civrs_pkg::REG_MAX_INDEX, 5'd0);
    send_frame(frame_item(11'b11111_0_10101, civrs_pkg::LEN_TWO_PAIRS_A,
                          16'd0, 16'hBEEF, 16'd1, 16'h1111));
    send_frame(query_item(civrs_pkg::OP_READ, 8'd0));
    send_frame(query_item(civrs_pkg::OP_FLAG, 8'd0));
    write_reg(civrs_pkg::REG_MAX_INDEX, 5'd16);
    send_frame(query_item(civrs_pkg::OP_READ, 8'd0));
  endtask

  task automatic test_random_traffic();
    logic [civrs_pkg::CFG_DATA_W-1:0] phase_addr [5];
    logic [civrs_pkg::CFG_DATA_W-1:0] phase_max [5];
    phase_addr = '{5'($urandom), 5'd31, 5'd0, 5'($urandom), 5'($urandom)};
    phase_max = '{5'd16, 5'($urandom_range(1, 15)), 5'd0, 5'($urandom_range(1, 15)), 5'd16};
    for (int p = 0; p < 5; p++) begin
      write_reg(civrs_pkg::REG_MODULE_ADDRESS, phase_addr[p]);
      write_reg(civrs_pkg::REG_MAX_INDEX, phase_max[p]);
      for (int n = 0; n < 114; n++) begin
        if (n % 40 == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            sender_gap_max = 0;
            reader_stall_max = 0;
          end else begin
            sender_gap_max = 19;
            reader_stall_max = 19;
          end
        end
        send_frame(random_frame());
      end
    end
    sender_gap_max = 19;
    reader_stall_max = 19;
  endtask

  task automatic test_output_backpressure();
    settle_block();
    hold_request = HOLD_CYCLES;
    repeat (2) @(posedge clk);
    sender_gap_max = 0;
    for (int n = 0; n < 24; n++) begin
      send_frame(query_item((n % 2 == 0) ? civrs_pkg::OP_READ : civrs_pkg::OP_FLAG,
                            8'($urandom_range(0, DEPTH + 1))));
    end
    sender_gap_max = 19;
  endtask

  task automatic test_drain_pause();
    for (int n = 0; n < 20; n++) send_frame(random_frame());
    settle_block();
    for (int n = 0; n < 10; n++) send_frame(random_frame());
  endtask

  initial begin : reader
    int stall;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = $urandom_range(0, reader_stall_max);
      end
      if (stall > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid && hold_request == 0);
    end
  end

  always @(posedge clk) begin : result_check
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result transfer: read_value %h flag_was_set %b",
               m_tdata[civrs_pkg::WORD16_W-1:0], m_tdata[civrs_pkg::FLAG_BIT]);
        fail_count++;
      end else begin
        want = reply_q.pop_front();
        if (m_tdata[civrs_pkg::WORD16_W-1:0] !== want.value) begin
          $error("read_value: expected %h, actual %h", want.value,
                 m_tdata[civrs_pkg::WORD16_W-1:0]);
          fail_count++;
        end
        if (m_tdata[civrs_pkg::FLAG_BIT] !== want.flag) begin
          $error("flag_was_set: expected %b, actual %b", want.flag,
                 m_tdata[civrs_pkg::FLAG_BIT]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = civrs_pkg::OP_RECEIVE;
    cfg_we = 1'b0;
    cfg_index = civrs_pkg::REG_MODULE_ADDRESS;
    cfg_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      mbx_value[i] = '0;
      mbx_flag[i] = 1'b0;
    end
    addr_now = civrs_pkg::MODULE_ADDRESS_RESET;
    max_now = civrs_pkg::MAX_INDEX_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_contents();
    test_frame_storage();
    test_value_and_flag_reads();
    test_range_clear();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();
    test_drain_pause();

    settle_block();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/civrs_pkg.sv
hdl/can_index_value_receive_store.sv
verif/can_index_value_receive_store_tb.sv
